@@ src/ola_pkg.sv @@
// ----------------------------------------------------------------------------
// ola_pkg
// Shared types and codes for the ordered value list with remove by value.
// ----------------------------------------------------------------------------
package ola_pkg;

  localparam int DEPTH_DEF = 32;
  localparam int VAL_W     = 32;

  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [2:0] ST_APPENDED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_REMOVED   = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_ENTRY     = 3'd4;
  localparam logic [2:0] ST_EMPTY     = 3'd5;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [VAL_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic signed [VAL_W-1:0] entry_value;
    logic                    last;
  } rsp_t;

  // Command handed from the front queue to the back sequencer
  typedef struct packed {
    logic [1:0]       op;
    logic [VAL_W-1:0] value;
  } cmd_t;

endpackage

@@ src/ola_ram.sv @@
// ----------------------------------------------------------------------------
// ola_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ola_ram #(
  parameter int W = 32,
  parameter int D = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/ola_front.sv @@
// ----------------------------------------------------------------------------
// ola_front
// Accepts request items, drops undefined ops and queues commands (2 deep).
// ----------------------------------------------------------------------------
module ola_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ola_pkg::req_t req,
  output logic          cmd_valid,
  output ola_pkg::cmd_t cmd,
  input  logic          cmd_pop
);
  import ola_pkg::*;

  cmd_t       q_data [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] q_cnt;
  logic       push;
  logic       take;

  assign req_stall = (q_cnt == 2'd2);
  assign take      = req_valid && !req_stall;
  // op code 3 is accepted and dropped
  assign push      = take && (req.op inside {OP_APPEND, OP_REMOVE, OP_READ});
  assign cmd_valid = (q_cnt != 2'd0);
  assign cmd       = q_data[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_data[wr_ptr] <= '{op: req.op, value: req.value};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      q_cnt  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, cmd_pop})
        2'b10:   q_cnt <= q_cnt + 2'd1;
        2'b01:   q_cnt <= q_cnt - 2'd1;
        default: q_cnt <= q_cnt;
      endcase
    end
  end

endmodule

@@ src/ola_back.sv @@
// ----------------------------------------------------------------------------
// ola_back
// Sequencer that carries out append, remove and readout on the entry RAM
// and drives the registered result port.
// ----------------------------------------------------------------------------
module ola_back #(
  parameter int DEPTH = ola_pkg::DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  ola_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  output logic                       rsp_valid,
  input  logic                       rsp_stall,
  output ola_pkg::rsp_t              rsp,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  import ola_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH+1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRD  = 3'd1;
  localparam logic [2:0] S_SCMP = 3'd2;
  localparam logic [2:0] S_SHRD = 3'd3;
  localparam logic [2:0] S_SHWR = 3'd4;
  localparam logic [2:0] S_RES  = 3'd5;
  localparam logic [2:0] S_RRD  = 3'd6;
  localparam logic [2:0] S_RSND = 3'd7;

  logic [2:0]       state, state_next;
  logic [AW-1:0]    ptr, ptr_next;
  logic [CW-1:0]    count_next;
  logic [VAL_W-1:0] val, val_next;
  logic [2:0]       res, res_next;
  logic             rsp_valid_next;
  rsp_t             rsp_next;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic [AW-1:0]    raddr;
  logic [VAL_W-1:0] rdata;

  logic [CW-1:0]    ptr_p1;
  logic [CW-1:0]    ptr_p2;
  logic             slot_free;

  assign ptr_p1    = CW'(ptr) + CW'(1);
  assign ptr_p2    = CW'(ptr) + CW'(2);
  assign slot_free = !rsp_valid || !rsp_stall;
  assign raddr     = (state == S_SHRD) ? ptr_p1[AW-1:0] : ptr;

  ola_ram #(.W(VAL_W), .D(DEPTH)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_next     = state;
    ptr_next       = ptr;
    count_next     = count;
    val_next       = val;
    res_next       = res;
    cmd_pop        = 1'b0;
    we             = 1'b0;
    waddr          = ptr;
    wdata          = rdata;
    rsp_valid_next = rsp_valid && rsp_stall;
    rsp_next       = rsp;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop  = 1'b1;
          val_next = cmd.value;
          ptr_next = '0;
          case (cmd.op)
            OP_APPEND: begin
              if (count == CW'(DEPTH)) begin
                res_next = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = count[AW-1:0];
                wdata      = cmd.value;
                count_next = count + CW'(1);
                res_next   = ST_APPENDED;
              end
              state_next = S_RES;
            end
            OP_REMOVE: begin
              if (count == '0) begin
                res_next   = ST_NOT_FOUND;
                state_next = S_RES;
              end else begin
                state_next = S_SRD;
              end
            end
            OP_READ: begin
              if (count == '0) begin
                res_next   = ST_EMPTY;
                state_next = S_RES;
              end else begin
                state_next = S_RRD;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_SRD: state_next = S_SCMP;
      S_SCMP: begin
        if (rdata == val) begin
          if (ptr_p1 == count) begin
            count_next = count - CW'(1);
            res_next   = ST_REMOVED;
            state_next = S_RES;
          end else begin
            state_next = S_SHRD;
          end
        end else if (ptr_p1 == count) begin
          res_next   = ST_NOT_FOUND;
          state_next = S_RES;
        end else begin
          ptr_next   = ptr + AW'(1);
          state_next = S_SRD;
        end
      end
      S_SHRD: state_next = S_SHWR;
      S_SHWR: begin
        // close the gap: entry ptr takes entry ptr+1
        we       = 1'b1;
        waddr    = ptr;
        wdata    = rdata;
        ptr_next = ptr + AW'(1);
        if (ptr_p2 == count) begin
          count_next = count - CW'(1);
          res_next   = ST_REMOVED;
          state_next = S_RES;
        end else begin
          state_next = S_SHRD;
        end
      end
      S_RES: begin
        if (slot_free) begin
          rsp_valid_next = 1'b1;
          rsp_next       = '{status: res, entry_value: '0, last: 1'b1};
          state_next     = S_IDLE;
        end
      end
      S_RRD: state_next = S_RSND;
      S_RSND: begin
        // read data holds while waiting, since the address is unchanged
        if (slot_free) begin
          rsp_valid_next = 1'b1;
          rsp_next       = '{status: ST_ENTRY, entry_value: rdata,
                             last: (ptr_p1 == count)};
          if (ptr_p1 == count) begin
            state_next = S_IDLE;
          end else begin
            ptr_next   = ptr + AW'(1);
            state_next = S_RRD;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr <= ptr_next;
    val <= val_next;
    res <= res_next;
    rsp <= rsp_next;
  end

endmodule

@@ src/ordered_list_append_remove_by_value.sv @@
// ----------------------------------------------------------------------------
// ordered_list_append_remove_by_value
// Ordered list of signed values with append, remove by value and readout.
// ----------------------------------------------------------------------------
// Append writes the entry as it is taken; remove searches from the first
// entry and on a match moves each later entry up one place; readout gives
// one result per entry. The back sequencer works one item at a time; each
// entry visit costs a RAM read and a compare, write-back or result. A
// 2-deep command queue lets up to two items be accepted while one runs.
// Reset empties the list at once; no clearing pass.
module ordered_list_append_remove_by_value #(
  parameter int DEPTH = ola_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ola_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ola_pkg::rsp_t rsp
);
  import ola_pkg::*;

  localparam int CW = $clog2(DEPTH+1);

  logic          cmd_valid;
  cmd_t          cmd;
  logic          cmd_pop;
  logic [CW-1:0] count;

  ola_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ola_back #(.DEPTH(DEPTH)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .count     (count)
  );

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command popped from empty queue");

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (count == $past(count) || count == $past(count) + CW'(1)
                     || count + CW'(1) == $past(count)))
    else $error("entry count moved by more than one");

  a_status_form: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_ENTRY |-> rsp.last && rsp.entry_value == '0)
    else $error("non-entry result not last or carries a value");

endmodule
